### rtl/mei_pkg.sv
`default_nettype none

package mei_pkg;

    localparam int SAMPLE_RATE_HZ_DEF = 100000;
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 28;

    localparam int COEF_WIDTH  = 32;
    localparam int HIST_WIDTH  = 32;
    localparam int ACC_WIDTH   = 64;
    localparam int COEF_COUNT  = 16;
    localparam int STEP_WIDTH  = 5;

    localparam logic signed [ACC_WIDTH-1:0] HIST_MAX = 64'sd2147483647;
    localparam logic signed [ACC_WIDTH-1:0] HIST_MIN = -64'sd2147483648;

    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [63:0] PREWARP_HZ = 64'd1000;
    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
    localparam logic signed [63:0] Q16_ONE = 64'sd65536;

    // Per section, all scaled by ten: denominator k and c, whether the
    // numerator has the C squared term, numerator k and c.
    localparam logic signed [63:0] SECT_DEN_K [3] = '{64'sd59761, 64'sd64255, 64'sd248910};
    localparam logic signed [63:0] SECT_DEN_C [3] =
        '{64'sd252550000, 64'sd1397500000, 64'sd12700000000};
    localparam logic SECT_NUM_C2 [3] = '{1'b1, 1'b1, 1'b0};
    localparam logic signed [63:0] SECT_NUM_K [3] = '{64'sd56665, 64'sd58934, 64'sd31137};
    localparam logic signed [63:0] SECT_NUM_C [3] = '{64'sd0, 64'sd1792600000, 64'sd6976800000};

    typedef logic [COEF_COUNT-1:0][COEF_WIDTH-1:0] coef_tab_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_X,
        OP_P1,
        OP_P2,
        OP_S1_1,
        OP_S1_2,
        OP_S2_1,
        OP_S2_2,
        OP_S3_1,
        OP_S3_2
    } mei_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } mei_acc_t;

    typedef enum logic [2:0] {
        HW_NONE,
        HW_SEC1,
        HW_SEC2,
        HW_SEC3,
        HW_OUT
    } mei_hw_t;

    typedef enum logic {
        J_NEXT,
        J_DONE
    } mei_jmp_t;

    typedef struct packed {
        mei_op_t  op;
        logic [3:0] coef;
        mei_acc_t acc;
        mei_hw_t  hw;
        mei_jmp_t jmp;
    } mei_uword_t;

    typedef struct packed {
        logic       run;
        logic       load;
        logic       clear;
        mei_uword_t uw;
    } mei_ctrl_t;

    // Restoring division, one quotient bit per iteration.
    function automatic logic [63:0] mei_udiv(input logic [127:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q = '0;
        for (int i = 127; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            q = {q[62:0], 1'b0};
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mei_mul_q30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b + (64'd1 << 29);
        return p >> 30;
    endfunction

    function automatic logic [63:0] mei_q30_ratio(input logic [63:0] n, input logic [63:0] d);
        return mei_udiv({64'd0, (n << 30) + (d >> 1)}, d);
    endfunction

    function automatic logic [COEF_WIDTH-1:0] mei_coef_div(input logic signed [63:0] num,
                                                           input logic signed [63:0] den,
                                                           input int frac);
        logic [63:0]  mag;
        logic [63:0]  q;
        logic [127:0] wide;
        logic         neg;
        if (den <= 0)
        begin
            return '0;
        end
        neg = num < 0;
        mag = neg ? 64'(-num) : 64'(num);
        wide = {64'd0, mag} << (frac + 1);
        q = mei_udiv(wide, 64'(den));
        q = (q + 64'd1) >> 1;
        if (q > 64'h8000_0000)
        begin
            q = 64'h8000_0000;
        end
        if (neg)
        begin
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF)
        begin
            q = 64'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    // Bilinear transform with prewarping at 1 kHz; C = w / tan(w / 2fs).
    function automatic coef_tab_t mei_build_coefs(input int fs_hz, input int frac);
        logic [63:0] fs;
        logic [63:0] x;
        logic [63:0] z;
        logic [63:0] h;
        logic [63:0] s;
        logic [63:0] cq;
        logic signed [63:0] p2;
        logic signed [63:0] cc;
        logic signed [63:0] cs;
        logic signed [63:0] den;
        logic signed [63:0] bp;
        logic signed [63:0] s0;
        coef_tab_t tab;
        tab = '0;
        fs = 64'(fs_hz);
        x = mei_udiv({64'd0, PI_Q30 * PREWARP_HZ + (fs >> 1)}, fs);
        z = mei_mul_q30(x, x);
        h = mei_q30_ratio(64'd1382, 64'd638512875);
        h = mei_q30_ratio(64'd2, 64'd93555) + mei_mul_q30(z, h);
        h = mei_q30_ratio(64'd1, 64'd4725) + mei_mul_q30(z, h);
        h = mei_q30_ratio(64'd2, 64'd945) + mei_mul_q30(z, h);
        h = mei_q30_ratio(64'd1, 64'd45) + mei_mul_q30(z, h);
        h = mei_q30_ratio(64'd1, 64'd3) + mei_mul_q30(z, h);
        s = ONE_Q30 - mei_mul_q30(z, h);
        cq = (64'd2 * fs * s + (64'd1 << 21)) >> 22;
        p2 = $signed(cq * cq) * 64'sd10;
        cc = $signed(cq << 8);
        for (int k = 0; k < 3; k++)
        begin
            cs = SECT_DEN_C[k] * Q16_ONE;
            den = p2 + SECT_DEN_K[k] * cc + cs;
            bp = SECT_NUM_C2[k] ? p2 : 64'sd0;
            s0 = SECT_NUM_C[k] * Q16_ONE;
            tab[5*k]     = mei_coef_div(bp + SECT_NUM_K[k] * cc + s0, den, frac);
            tab[5*k + 1] = mei_coef_div(64'sd2 * s0 - 64'sd2 * bp, den, frac);
            tab[5*k + 2] = mei_coef_div(bp - SECT_NUM_K[k] * cc + s0, den, frac);
            tab[5*k + 3] = mei_coef_div(64'sd2 * cs - 64'sd2 * p2, den, frac);
            tab[5*k + 4] = mei_coef_div(p2 - SECT_DEN_K[k] * cc + cs, den, frac);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

### rtl/mei_in_if.sv
`default_nettype none

interface mei_in_if #(
    parameter int W = mei_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample;
    logic                start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink (input valid, input sample, input start_req, output ready);
endinterface

`default_nettype wire

### rtl/mei_out_if.sv
`default_nettype none

interface mei_out_if #(
    parameter int W = mei_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink (input valid, input filtered, output ready);
endinterface

`default_nettype wire

### rtl/mei_seq.sv
`default_nettype none

module mei_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              start_req,
    input  wire logic              out_busy,
    output logic                   in_ready,
    output mei_pkg::mei_ctrl_t     ctrl
);
    import mei_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic [STEP_WIDTH-1:0] step_reg;
    logic [STEP_WIDTH-1:0] step_next;
    mei_uword_t            uw;
    logic                  stall;
    logic                  accept;

    // Each section runs its five products in the order b1, b2, a1, a2, b0, so
    // the products that do not need the previous section's result go first.
    function automatic mei_uword_t ucode(input logic [STEP_WIDTH-1:0] s);
        mei_uword_t w;
        w = '{op: OP_NONE, coef: 4'd0, acc: ACC_HOLD, hw: HW_NONE, jmp: J_NEXT};
        unique case (s)
            5'd0:  w = '{OP_P1,   4'd1,  ACC_HOLD, HW_NONE, J_NEXT};
            5'd1:  w = '{OP_P2,   4'd2,  ACC_LOAD, HW_NONE, J_NEXT};
            5'd2:  w = '{OP_S1_1, 4'd3,  ACC_ADD,  HW_NONE, J_NEXT};
            5'd3:  w = '{OP_S1_2, 4'd4,  ACC_SUB,  HW_NONE, J_NEXT};
            5'd4:  w = '{OP_X,    4'd0,  ACC_SUB,  HW_NONE, J_NEXT};
            5'd5:  w = '{OP_S1_1, 4'd6,  ACC_ADD,  HW_NONE, J_NEXT};
            5'd6:  w = '{OP_S1_2, 4'd7,  ACC_LOAD, HW_SEC1, J_NEXT};
            5'd7:  w = '{OP_S2_1, 4'd8,  ACC_ADD,  HW_NONE, J_NEXT};
            5'd8:  w = '{OP_S2_2, 4'd9,  ACC_SUB,  HW_NONE, J_NEXT};
            5'd9:  w = '{OP_S1_1, 4'd5,  ACC_SUB,  HW_NONE, J_NEXT};
            5'd10: w = '{OP_S2_1, 4'd11, ACC_ADD,  HW_NONE, J_NEXT};
            5'd11: w = '{OP_S2_2, 4'd12, ACC_LOAD, HW_SEC2, J_NEXT};
            5'd12: w = '{OP_S3_1, 4'd13, ACC_ADD,  HW_NONE, J_NEXT};
            5'd13: w = '{OP_S3_2, 4'd14, ACC_SUB,  HW_NONE, J_NEXT};
            5'd14: w = '{OP_S2_1, 4'd10, ACC_SUB,  HW_NONE, J_NEXT};
            5'd15: w = '{OP_NONE, 4'd0,  ACC_ADD,  HW_NONE, J_NEXT};
            5'd16: w = '{OP_NONE, 4'd0,  ACC_HOLD, HW_SEC3, J_NEXT};
            5'd17: w = '{OP_NONE, 4'd0,  ACC_HOLD, HW_OUT,  J_DONE};
            default: w = '{OP_NONE, 4'd0, ACC_HOLD, HW_NONE, J_DONE};
        endcase
        return w;
    endfunction

    always_comb
    begin
        uw = ucode(step_reg);
        stall = (uw.hw == HW_OUT) && out_busy;
        in_ready = !busy_reg || (uw.jmp == J_DONE && !stall);
        accept = in_valid && in_ready;

        busy_next = busy_reg;
        step_next = step_reg;
        if (busy_reg && !stall)
        begin
            unique case (uw.jmp)
                J_NEXT: step_next = step_reg + 1'b1;
                J_DONE: busy_next = 1'b0;
                default: busy_next = 1'b0;
            endcase
        end
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end

        ctrl.run = busy_reg && !stall;
        ctrl.load = accept;
        ctrl.clear = accept && start_req;
        ctrl.uw = uw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mei_dp.sv
`default_nettype none

module mei_dp #(
    parameter int SAMPLE_RATE_HZ = mei_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int SAMPLE_WIDTH   = mei_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = mei_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mei_pkg::mei_ctrl_t             ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      filtered,
    output logic                                out_busy
);
    import mei_pkg::*;

    localparam coef_tab_t COEFS = mei_build_coefs(SAMPLE_RATE_HZ, COEF_FRAC_BITS);
    localparam logic signed [ACC_WIDTH-1:0] RND = 64'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [32:0] OUT_MAX = (33'sd1 <<< (SAMPLE_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] OUT_MIN = -(33'sd1 <<< (SAMPLE_WIDTH - 1));

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] p1_reg;
    logic signed [SAMPLE_WIDTH-1:0] p2_reg;
    logic signed [HIST_WIDTH-1:0]   s1_1_reg;
    logic signed [HIST_WIDTH-1:0]   s1_2_reg;
    logic signed [HIST_WIDTH-1:0]   s2_1_reg;
    logic signed [HIST_WIDTH-1:0]   s2_2_reg;
    logic signed [HIST_WIDTH-1:0]   s3_1_reg;
    logic signed [HIST_WIDTH-1:0]   s3_2_reg;
    logic signed [ACC_WIDTH-1:0]    prod_reg;
    logic signed [ACC_WIDTH-1:0]    acc_reg;
    logic signed [ACC_WIDTH-1:0]    acc_next;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] filtered_reg;
    logic signed [SAMPLE_WIDTH-1:0] filtered_next;

    logic signed [HIST_WIDTH-1:0]   opnd;
    logic signed [COEF_WIDTH-1:0]   coef;
    logic signed [ACC_WIDTH-1:0]    rnd_sum;
    logic signed [ACC_WIDTH-1:0]    rnd_shift;
    logic signed [HIST_WIDTH-1:0]   y;
    logic signed [32:0]             o_sum;
    logic signed [32:0]             o_half;

    always_comb
    begin
        unique case (ctrl.uw.op)
            OP_X:    opnd = 32'(x_reg);
            OP_P1:   opnd = 32'(p1_reg);
            OP_P2:   opnd = 32'(p2_reg);
            OP_S1_1: opnd = s1_1_reg;
            OP_S1_2: opnd = s1_2_reg;
            OP_S2_1: opnd = s2_1_reg;
            OP_S2_2: opnd = s2_2_reg;
            OP_S3_1: opnd = s3_1_reg;
            OP_S3_2: opnd = s3_2_reg;
            default: opnd = '0;
        endcase
        coef = $signed(COEFS[ctrl.uw.coef]);

        unique case (ctrl.uw.acc)
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            ACC_SUB:  acc_next = acc_reg - prod_reg;
            default:  acc_next = acc_reg;
        endcase

        // Round half up, then saturate the section output to 32 bits.
        rnd_sum = acc_reg + RND;
        rnd_shift = rnd_sum >>> COEF_FRAC_BITS;
        if (rnd_shift > HIST_MAX)
        begin
            y = HIST_MAX[HIST_WIDTH-1:0];
        end
        else if (rnd_shift < HIST_MIN)
        begin
            y = HIST_MIN[HIST_WIDTH-1:0];
        end
        else
        begin
            y = rnd_shift[HIST_WIDTH-1:0];
        end

        // Halve the last section output with rounding half up, then saturate it.
        o_sum = 33'(s3_1_reg) + 33'sd1;
        o_half = o_sum >>> 1;
        if (o_half > OUT_MAX)
        begin
            filtered_next = OUT_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (o_half < OUT_MIN)
        begin
            filtered_next = OUT_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            filtered_next = o_half[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= sample;
        end
        if (ctrl.run)
        begin
            prod_reg <= coef * opnd;
            acc_reg <= acc_next;
        end
        if (ctrl.run && ctrl.uw.hw == HW_OUT)
        begin
            filtered_reg <= filtered_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            s1_1_reg <= '0;
            s1_2_reg <= '0;
            s2_1_reg <= '0;
            s2_2_reg <= '0;
            s3_1_reg <= '0;
            s3_2_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            s1_1_reg <= '0;
            s1_2_reg <= '0;
            s2_1_reg <= '0;
            s2_2_reg <= '0;
            s3_1_reg <= '0;
            s3_2_reg <= '0;
        end
        else if (ctrl.run)
        begin
            unique case (ctrl.uw.hw)
                HW_SEC1:
                begin
                    s1_2_reg <= s1_1_reg;
                    s1_1_reg <= y;
                end
                HW_SEC2:
                begin
                    s2_2_reg <= s2_1_reg;
                    s2_1_reg <= y;
                end
                HW_SEC3:
                begin
                    s3_2_reg <= s3_1_reg;
                    s3_1_reg <= y;
                    p2_reg <= p1_reg;
                    p1_reg <= x_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.run && ctrl.uw.hw == HW_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered = filtered_reg;
    assign out_busy = out_valid_reg && !out_ready;

endmodule

`default_nettype wire

### rtl/middle_ear_iir_filter.sv
// Middle ear filter: three cascaded second-order IIR sections with fixed
// coefficients, followed by a halving, saturated output stage.
// The din channel carries one word per sample: a signed sample and a
// start_req flag; start_req clears all filter history before that sample.
// The dout channel returns one filtered word per input word, in order.
// A single 32 x 32 multiplier and a 64-bit accumulator are shared by all
// fifteen products under a microcode program of 18 steps.
// The program length sets the word rate; the next word is taken in the same
// cycle as the last step of the previous one, unless that step must wait.
// The output register holds a result while the receiver stalls; the next word
// is still accepted and processed, and its last step waits for the register.
// Reset clears the history, the sequencer and the output valid flag; the
// coefficients are constants computed from the parameters at elaboration.
`default_nettype none

module middle_ear_iir_filter #(
    parameter int SAMPLE_RATE_HZ = mei_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int SAMPLE_WIDTH   = mei_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = mei_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mei_in_if.sink     din,
    mei_out_if.source  dout
);
    import mei_pkg::*;

    mei_ctrl_t ctrl;
    logic      out_busy;
    logic      in_ready;
    logic      out_valid;
    logic signed [SAMPLE_WIDTH-1:0] filtered;

    mei_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .start_req (din.start_req),
        .out_busy  (out_busy),
        .in_ready  (in_ready),
        .ctrl      (ctrl)
    );

    mei_dp #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample    (din.sample),
        .out_ready (dout.ready),
        .out_valid (out_valid),
        .filtered  (filtered),
        .out_busy  (out_busy)
    );

    assign din.ready = in_ready;
    assign dout.valid = out_valid;
    assign dout.filtered = filtered;

endmodule

`default_nettype wire

### rtl/mei_chk.sv
`default_nettype none

module mei_chk #(
    parameter int W = mei_pkg::SAMPLE_WIDTH_DEF
) (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         in_valid,
    input wire logic         in_ready,
    input wire logic         out_valid,
    input wire logic         out_ready,
    input wire logic [W-1:0] filtered
);
    logic       in_acc;
    logic       out_acc;
    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;

    assign in_acc = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // Only one word is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input taken again right after a word was accepted");

    a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> inflight_reg != 2'd0)
        else $error("result word delivered with no word outstanding");

    a_bounded_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more than two words outstanding");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered))
        else $error("stalled result word dropped or changed");

endmodule

bind middle_ear_iir_filter mei_chk #(.W(SAMPLE_WIDTH)) u_mei_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .filtered  (dout.filtered)
);

`default_nettype wire

### sim/middle_ear_iir_filter_tb.sv
`default_nettype none

module middle_ear_iir_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW             = mei_pkg::SAMPLE_WIDTH_DEF;
    localparam int FRAC           = mei_pkg::COEF_FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef longint unsigned u64_t;

    // Section constants, all scaled by ten: denominator k and c, whether the
    // numerator carries the squared prewarp term, numerator k and c.
    localparam longint SEC_DEN_K [3] = '{64'sd59761, 64'sd64255, 64'sd248910};
    localparam longint SEC_DEN_C [3] = '{64'sd252550000, 64'sd1397500000, 64'sd12700000000};
    localparam bit     SEC_NUM_C2 [3] = '{1'b1, 1'b1, 1'b0};
    localparam longint SEC_NUM_K [3] = '{64'sd56665, 64'sd58934, 64'sd31137};
    localparam longint SEC_NUM_C [3] = '{64'sd0, 64'sd1792600000, 64'sd6976800000};

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 start_req;
    } audio_word_t;

    logic clk;
    logic rst_n;

    mei_in_if  din_if ();
    mei_out_if dout_if ();

    middle_ear_iir_filter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    audio_word_t          pending_words [$];
    logic signed [SW-1:0] expected_filtered [$];

    int band_coef [3][5];
    longint prior_in1 = 0;
    longint prior_in2 = 0;
    int sec_hist1 [3] = '{0, 0, 0};
    int sec_hist2 [3] = '{0, 0, 0};

    int send_idle_pct;
    int recv_idle_pct;
    int queued_words   = 0;
    int accepted_words = 0;
    int checked_words  = 0;
    int signal_starts  = 0;
    int rail_hits      = 0;
    int fail_count     = 0;
    int idle_cycles    = 0;

    audio_word_t          next_word;
    logic signed [SW-1:0] want;
    longint               x_in;
    longint               out_wide;
    int                   y_sec [3];
    bit                   moved;

    function automatic u64_t q30_div(input u64_t n, input u64_t d);
        return ((n << 30) + d / 2) / d;
    endfunction

    function automatic u64_t q30_mul(input u64_t a, input u64_t b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic int round_coef_div(input longint num, input longint den);
        bit   neg;
        u64_t mag;
        u64_t d;
        u64_t q;
        u64_t r;
        if (den <= 0)
        begin
            return 0;
        end
        neg = num < 0;
        mag = neg ? u64_t'(-num) : u64_t'(num);
        d = u64_t'(den);
        q = mag / d;
        r = mag % d;
        for (int i = 0; i < FRAC + 1; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        q = (q + 64'd1) >> 1;
        if (q > 64'h8000_0000)
        begin
            q = 64'h8000_0000;
        end
        if (neg)
        begin
            return int'(-longint'(q));
        end
        if (q > 64'h7FFF_FFFF)
        begin
            q = 64'h7FFF_FFFF;
        end
        return int'(q);
    endfunction

    function automatic int biquad_step(input int k, input longint x0, input longint x1,
                                       input longint x2, input longint y1, input longint y2);
        longint acc;
        longint v;
        acc = longint'(band_coef[k][0]) * x0 + longint'(band_coef[k][1]) * x1
            + longint'(band_coef[k][2]) * x2 - longint'(band_coef[k][3]) * y1
            - longint'(band_coef[k][4]) * y2;
        acc = acc + (64'sd1 <<< (FRAC - 1));
        v = acc >>> FRAC;
        if (v > 64'sd2147483647)
        begin
            v = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            v = -64'sd2147483648;
        end
        return int'(v);
    endfunction

    task automatic queue_word(input logic signed [SW-1:0] smp, input logic clr);
        audio_word_t w;
        w.sample = smp;
        w.start_req = clr;
        pending_words.push_back(w);
        queued_words++;
    endtask

    task automatic drain_all();
        while (accepted_words != queued_words || expected_filtered.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly short signals that open with a start request, each of one
    // character: full-scale noise, small noise, square waves, DC, or rails.
    task automatic queue_random_signals(input int n);
        int                   made;
        int                   seg_len;
        int                   kind;
        int                   amp;
        int                   period;
        int                   v;
        bit                   opens;
        logic signed [SW-1:0] smp;
        logic signed [SW-1:0] dc;
        made = 0;
        while (made < n)
        begin
            seg_len = $urandom_range(4, 64);
            kind = $urandom_range(0, 9);
            amp = 1 << $urandom_range(0, SW - 2);
            period = $urandom_range(1, 8);
            dc = SW'($urandom);
            opens = $urandom_range(0, 9) < 8;
            for (int i = 0; i < seg_len && made < n; i++)
            begin
                case (kind)
                    4, 5:
                    begin
                        v = int'($urandom_range(0, 2 * amp)) - amp;
                        smp = SW'(v);
                    end
                    6: smp = ((i / period) % 2) ? SAMPLE_MAX : SAMPLE_MIN;
                    7: smp = dc;
                    8: smp = (i % 2) ? SW'(amp - 1) : SW'(-amp);
                    9:
                    begin
                        case ($urandom_range(0, 4))
                            0: smp = SAMPLE_MAX;
                            1: smp = SAMPLE_MIN;
                            2: smp = '0;
                            3: smp = '1;
                            default: smp = SW'(1);
                        endcase
                    end
                    default: smp = SW'($urandom);
                endcase
                queue_word(smp, (i == 0 && opens) || $urandom_range(0, 199) == 0);
                made++;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            din_if.valid <= 1'b0;
            din_if.sample <= '0;
            din_if.start_req <= 1'b0;
        end
        else if (!din_if.valid || din_if.ready)
        begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_word = pending_words.pop_front();
                din_if.valid <= 1'b1;
                din_if.sample <= next_word.sample;
                din_if.start_req <= next_word.start_req;
            end
            else
            begin
                din_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
        end
        else
        begin
            dout_if.ready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (dout_if.valid && dout_if.ready)
            begin
                moved = 1'b1;
                if (expected_filtered.size() == 0)
                begin
                    $display("%0t: filtered word %0d arrived with none expected",
                             $time, dout_if.filtered);
                    fail_count++;
                end
                else
                begin
                    want = expected_filtered.pop_front();
                    if (dout_if.filtered !== want)
                    begin
                        $display("%0t: filtered mismatch, expected %0d, got %0d",
                                 $time, want, dout_if.filtered);
                        fail_count++;
                    end
                    checked_words++;
                    if (want == SAMPLE_MAX || want == SAMPLE_MIN)
                    begin
                        rail_hits++;
                    end
                end
            end
            if (din_if.valid && din_if.ready)
            begin
                moved = 1'b1;
                x_in = din_if.sample;
                if (din_if.start_req)
                begin
                    prior_in1 = 0;
                    prior_in2 = 0;
                    for (int k = 0; k < 3; k++)
                    begin
                        sec_hist1[k] = 0;
                        sec_hist2[k] = 0;
                    end
                    signal_starts++;
                end
                y_sec[0] = biquad_step(0, x_in, prior_in1, prior_in2, sec_hist1[0], sec_hist2[0]);
                y_sec[1] = biquad_step(1, y_sec[0], sec_hist1[0], sec_hist2[0],
                                       sec_hist1[1], sec_hist2[1]);
                y_sec[2] = biquad_step(2, y_sec[1], sec_hist1[1], sec_hist2[1],
                                       sec_hist1[2], sec_hist2[2]);
                prior_in2 = prior_in1;
                prior_in1 = x_in;
                for (int k = 0; k < 3; k++)
                begin
                    sec_hist2[k] = sec_hist1[k];
                    sec_hist1[k] = y_sec[k];
                end
                out_wide = (longint'(y_sec[2]) + 64'sd1) >>> 1;
                if (out_wide > longint'(SAMPLE_MAX))
                begin
                    out_wide = longint'(SAMPLE_MAX);
                end
                else if (out_wide < longint'(SAMPLE_MIN))
                begin
                    out_wide = longint'(SAMPLE_MIN);
                end
                expected_filtered.push_back(SW'(out_wide));
                accepted_words++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        u64_t   fs;
        u64_t   x;
        u64_t   z;
        u64_t   h;
        u64_t   s;
        u64_t   cq;
        longint p2;
        longint cc;
        longint cs;
        longint den;
        longint bp;
        longint s0;

        rst_n = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 46;

        // The prewarped bilinear constant comes from a Taylor series of
        // x*cot(x) in Q30, then the coefficients are rounded to Q4.28.
        fs = u64_t'(mei_pkg::SAMPLE_RATE_HZ_DEF);
        x = (64'd3373259426 * 64'd1000 + fs / 2) / fs;
        z = q30_mul(x, x);
        h = q30_div(1382, 638512875);
        h = q30_div(2, 93555) + q30_mul(z, h);
        h = q30_div(1, 4725) + q30_mul(z, h);
        h = q30_div(2, 945) + q30_mul(z, h);
        h = q30_div(1, 45) + q30_mul(z, h);
        h = q30_div(1, 3) + q30_mul(z, h);
        s = (64'd1 << 30) - q30_mul(z, h);
        cq = (64'd2 * fs * s + (64'd1 << 21)) >> 22;
        p2 = longint'(cq * cq) * 64'sd10;
        cc = longint'(cq << 8);
        for (int k = 0; k < 3; k++)
        begin
            cs = SEC_DEN_C[k] * 64'sd65536;
            den = p2 + SEC_DEN_K[k] * cc + cs;
            bp = SEC_NUM_C2[k] ? p2 : 64'sd0;
            s0 = SEC_NUM_C[k] * 64'sd65536;
            band_coef[k][0] = round_coef_div(bp + SEC_NUM_K[k] * cc + s0, den);
            band_coef[k][1] = round_coef_div(64'sd2 * s0 - 64'sd2 * bp, den);
            band_coef[k][2] = round_coef_div(bp - SEC_NUM_K[k] * cc + s0, den);
            band_coef[k][3] = round_coef_div(64'sd2 * cs - 64'sd2 * p2, den);
            band_coef[k][4] = round_coef_div(p2 - SEC_DEN_K[k] * cc + cs, den);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        queue_word(SAMPLE_MAX, 1'b0);
        queue_word('0, 1'b0);
        queue_word('0, 1'b0);
        queue_word('0, 1'b0);
        queue_word(SAMPLE_MIN, 1'b1);
        queue_word('0, 1'b0);
        queue_word('0, 1'b0);
        queue_word(SAMPLE_MAX, 1'b1);
        for (int i = 0; i < 6; i++)
        begin
            queue_word(SAMPLE_MAX, 1'b0);
        end
        for (int i = 0; i < 6; i++)
        begin
            queue_word((i % 2) ? SAMPLE_MAX : SAMPLE_MIN, 1'b0);
        end
        queue_word('1, 1'b1);
        queue_word(SW'(1), 1'b0);
        queue_word(SAMPLE_MIN, 1'b0);
        queue_word(SAMPLE_MIN, 1'b0);
        drain_all();

        queue_random_signals(475);
        drain_all();
        send_idle_pct = 46;
        recv_idle_pct = 38;
        queue_random_signals(475);
        drain_all();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_signals(475);
        drain_all();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Filtered %0d samples over %0d signal starts under three flow-control mixes.",
                 checked_words, signal_starts);
        $display("%0d results sat on an output rail; %0d mismatches.", rail_hits, fail_count);
        if (fail_count == 0 && expected_filtered.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

### middle_ear_iir_filter.f
rtl/mei_pkg.sv
rtl/mei_in_if.sv
rtl/mei_out_if.sv
rtl/mei_seq.sv
rtl/mei_dp.sv
rtl/middle_ear_iir_filter.sv
rtl/mei_chk.sv
sim/middle_ear_iir_filter_tb.sv
